// ===== rtl/tfm_pkg.sv =====
// tfm_pkg: types and constants shared by the topic filter matcher
// no dependencies; compiled before the interfaces and modules

package tfm_pkg;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_FILTER = 2'd1,
        OP_TOPIC  = 2'd2,
        OP_END    = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        MODE_START   = 3'b001,
        MODE_LITERAL = 3'b010,
        MODE_PLUS    = 3'b100
    } mode_t;

    typedef enum logic [2:0] {
        VERDICT_PENDING = 3'b001,
        VERDICT_MATCHED = 3'b010,
        VERDICT_FAILED  = 3'b100
    } verdict_t;

    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] char_byte;
    } req_t;

    typedef struct packed {
        logic matched;
        logic filter_overflow;
    } rsp_t;

    typedef struct packed {
        logic valid;
        logic matched;
        logic filter_overflow;
    } verdict_out_t;

endpackage

// ===== rtl/tfm_if.sv =====
// tfm_req_if / tfm_rsp_if: valid-ready channels for requests and verdicts
// depends on tfm_pkg for the payload types

interface tfm_req_if import tfm_pkg::*;;
    logic valid;
    logic ready;
    req_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface tfm_rsp_if import tfm_pkg::*;;
    logic valid;
    logic ready;
    rsp_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/topic_filter_match.sv =====
// topic_filter_match: top level, input register, matcher, filter store, result register
// depends on tfm_pkg, tfm_if, tfm_filter_store and tfm_matcher
//
//   channel | direction | payload                      | transaction
//   req     | in        | operation, char_byte         | one filter or topic op
//   rsp     | out       | matched, filter_overflow     | one verdict per topic end
//
// one req transaction per cycle unless a pending verdict stalls a topic end;
// one request register and one result register; filter bytes come from a
// memory with registered reads addressed by the next topic position
// reset clears length, position and flags; the store is not cleared, entries at
// or beyond the filter length read as zero
// a pending verdict stalls only a later topic end, other ops keep flowing

module topic_filter_match import tfm_pkg::*; #(
    parameter int MAX_FILTER_LEN = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    tfm_req_if.sink      req,
    tfm_rsp_if.source    rsp
);

    localparam int AW = (MAX_FILTER_LEN > 1) ? $clog2(MAX_FILTER_LEN) : 1;
    localparam int LW = $clog2(MAX_FILTER_LEN + 1);

    logic         in_valid_reg;
    req_t         in_reg;
    logic         out_valid_reg;
    rsp_t         out_reg;
    logic         step;
    verdict_out_t verdict_out;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic [AW-1:0] rd_addr0, rd_addr1;
    logic [7:0]    rd_data0, rd_data1;

    assign step = in_valid_reg &&
                  (op_t'(in_reg.operation) != OP_END || !out_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            in_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.ready && req.valid)
        begin
            in_reg <= req.payload;
        end
    end

    tfm_matcher #(
        .MAX_FILTER_LEN(MAX_FILTER_LEN),
        .AW(AW),
        .LW(LW)
    ) u_matcher (
        .clk(clk),
        .rst_n(rst_n),
        .step(step),
        .item(in_reg),
        .rd_data0(rd_data0),
        .rd_data1(rd_data1),
        .wr_en(wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_addr0(rd_addr0),
        .rd_addr1(rd_addr1),
        .verdict_out(verdict_out)
    );

    tfm_filter_store #(
        .DEPTH(MAX_FILTER_LEN),
        .AW(AW)
    ) u_store (
        .clk(clk),
        .wr_en(wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_addr0(rd_addr0),
        .rd_addr1(rd_addr1),
        .rd_data0(rd_data0),
        .rd_data1(rd_data1)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (verdict_out.valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (verdict_out.valid)
        begin
            out_reg.matched         <= verdict_out.matched;
            out_reg.filter_overflow <= verdict_out.filter_overflow;
        end
    end

    assign rsp.valid   = out_valid_reg;
    assign rsp.payload = out_reg;

    // a new verdict never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        verdict_out.valid && out_valid_reg |-> rsp.ready)
        else $error("verdict overwritten");

    // every topic end leaves a verdict in the result register
    a_end_gives_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        step && op_t'(in_reg.operation) == OP_END |=> out_valid_reg)
        else $error("topic end without verdict");

    // a held request stays in the input register
    a_hold_request: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !step |=> in_valid_reg && $stable(in_reg))
        else $error("held request lost");

    // an overflowed filter never matches
    a_overflow_no_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.filter_overflow |-> !out_reg.matched)
        else $error("match reported on overflowed filter");

endmodule

// ===== rtl/tfm_filter_store.sv =====
// tfm_filter_store: filter byte memory, one write port, two registered read ports
// depends on nothing; a write to a read address is forwarded to that read

module tfm_filter_store #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic [AW-1:0] rd_addr0,
    input  logic [AW-1:0] rd_addr1,
    output logic [7:0]    rd_data0,
    output logic [7:0]    rd_data1
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd0_reg;
    logic [7:0] rd1_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd0_reg <= (wr_en && wr_addr == rd_addr0) ? wr_data : mem[rd_addr0];
        rd1_reg <= (wr_en && wr_addr == rd_addr1) ? wr_data : mem[rd_addr1];
    end

    assign rd_data0 = rd0_reg;
    assign rd_data1 = rd1_reg;

endmodule

// ===== rtl/tfm_matcher.sv =====
// tfm_matcher: filter length, topic position, segment mode and verdict state
// depends on tfm_pkg; reads the filter bytes at the position and the one after it

module tfm_matcher import tfm_pkg::*; #(
    parameter int MAX_FILTER_LEN = 64,
    parameter int AW             = 6,
    parameter int LW             = 7
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          step,
    input  req_t          item,
    input  logic [7:0]    rd_data0,
    input  logic [7:0]    rd_data1,
    output logic          wr_en,
    output logic [AW-1:0] wr_addr,
    output logic [7:0]    wr_data,
    output logic [AW-1:0] rd_addr0,
    output logic [AW-1:0] rd_addr1,
    output verdict_out_t  verdict_out
);

    logic [LW-1:0] len_reg, len_next;
    logic [LW-1:0] fp_reg, fp_next;
    logic          ovf_reg, ovf_next;
    mode_t         mode_reg, mode_next;
    verdict_t      verdict_reg, verdict_next;

    logic [LW-1:0] fp_p1, fp_p2, fp_nx1;
    logic          fp_in, fp1_in;
    logic [7:0]    s0, s1, c;
    logic          seg_end0, seg_end1, hash0, hash1;
    logic [LW-1:0] lit_fp;
    mode_t         lit_mode;
    verdict_t      lit_verdict;
    logic          end_match;

    assign c      = item.char_byte;
    assign fp_p1  = fp_reg + LW'(1);
    assign fp_p2  = fp_reg + LW'(2);
    assign fp_in  = fp_reg < len_reg;
    assign fp1_in = fp_in && (fp_p1 < len_reg);
    assign s0     = fp_in ? rd_data0 : 8'd0;
    assign s1     = fp1_in ? rd_data1 : 8'd0;

    assign seg_end0 = !fp_in || s0 == CH_SLASH;
    assign seg_end1 = !fp1_in || s1 == CH_SLASH;
    assign hash0    = fp_in && fp_p1 == len_reg && s0 == CH_HASH;
    assign hash1    = fp1_in && fp_p2 == len_reg && s1 == CH_HASH;

    // literal segment step
    always_comb
    begin
        lit_fp      = fp_reg;
        lit_mode    = MODE_LITERAL;
        lit_verdict = verdict_reg;
        if (c == CH_SLASH)
        begin
            if (seg_end0)
            begin
                lit_fp   = fp_in ? fp_p1 : fp_reg;
                lit_mode = MODE_START;
            end
            else
            begin
                lit_verdict = VERDICT_FAILED;
            end
        end
        else if (fp_in && s0 != CH_SLASH && s0 == c)
        begin
            lit_fp = fp_p1;
        end
        else
        begin
            lit_verdict = VERDICT_FAILED;
        end
    end

    // verdict at topic end
    always_comb
    begin
        if (ovf_reg || verdict_reg == VERDICT_FAILED)
        begin
            end_match = 1'b0;
        end
        else if (verdict_reg == VERDICT_MATCHED)
        begin
            end_match = 1'b1;
        end
        else if (mode_reg == MODE_START)
        begin
            end_match = hash0 || !fp_in;
        end
        else if (mode_reg == MODE_LITERAL && !seg_end0)
        begin
            end_match = 1'b0;
        end
        else if (fp_in)
        begin
            end_match = hash1 || !fp1_in;
        end
        else
        begin
            end_match = 1'b1;
        end
    end

    always_comb
    begin
        len_next     = len_reg;
        ovf_next     = ovf_reg;
        fp_next      = fp_reg;
        mode_next    = mode_reg;
        verdict_next = verdict_reg;
        wr_en        = 1'b0;
        verdict_out.valid           = 1'b0;
        verdict_out.matched         = end_match;
        verdict_out.filter_overflow = ovf_reg;
        if (step)
        begin
            unique case (op_t'(item.operation))
                OP_CLEAR:
                begin
                    len_next     = '0;
                    ovf_next     = 1'b0;
                    fp_next      = '0;
                    mode_next    = MODE_START;
                    verdict_next = VERDICT_PENDING;
                end
                OP_FILTER:
                begin
                    if (len_reg < LW'(MAX_FILTER_LEN))
                    begin
                        wr_en    = 1'b1;
                        len_next = len_reg + LW'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    fp_next      = '0;
                    mode_next    = MODE_START;
                    verdict_next = VERDICT_PENDING;
                end
                OP_TOPIC:
                begin
                    if (verdict_reg == VERDICT_PENDING)
                    begin
                        unique case (mode_reg)
                            MODE_START:
                            begin
                                if (hash0)
                                begin
                                    verdict_next = VERDICT_MATCHED;
                                end
                                else if (!fp_in)
                                begin
                                    verdict_next = VERDICT_FAILED;
                                end
                                else if (s0 == CH_PLUS && seg_end1)
                                begin
                                    if (c == CH_SLASH)
                                    begin
                                        fp_next   = fp1_in ? fp_p2 : fp_p1;
                                        mode_next = MODE_START;
                                    end
                                    else
                                    begin
                                        fp_next   = fp_p1;
                                        mode_next = MODE_PLUS;
                                    end
                                end
                                else
                                begin
                                    fp_next      = lit_fp;
                                    mode_next    = lit_mode;
                                    verdict_next = lit_verdict;
                                end
                            end
                            MODE_PLUS:
                            begin
                                if (c == CH_SLASH)
                                begin
                                    fp_next   = fp_in ? fp_p1 : fp_reg;
                                    mode_next = MODE_START;
                                end
                            end
                            MODE_LITERAL:
                            begin
                                fp_next      = lit_fp;
                                mode_next    = lit_mode;
                                verdict_next = lit_verdict;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                OP_END:
                begin
                    verdict_out.valid = 1'b1;
                    fp_next           = '0;
                    mode_next         = MODE_START;
                    verdict_next      = VERDICT_PENDING;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign fp_nx1   = fp_next + LW'(1);
    assign rd_addr0 = fp_next[AW-1:0];
    assign rd_addr1 = fp_nx1[AW-1:0];
    assign wr_addr  = len_reg[AW-1:0];
    assign wr_data  = c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg     <= '0;
            ovf_reg     <= 1'b0;
            fp_reg      <= '0;
            mode_reg    <= MODE_START;
            verdict_reg <= VERDICT_PENDING;
        end
        else
        begin
            len_reg     <= len_next;
            ovf_reg     <= ovf_next;
            fp_reg      <= fp_next;
            mode_reg    <= mode_next;
            verdict_reg <= verdict_next;
        end
    end

endmodule

// ===== bench/tfm_verdict_scoreboard.sv =====
// tfm_verdict_scoreboard: verdict predictor and result checker for topic_filter_match
// depends on tfm_pkg for the request, response, mode and verdict types

package tfm_verdict_sb_pkg;
    import tfm_pkg::*;

    localparam int FILTER_DEPTH = 64;

    class verdict_scoreboard;
        logic [7:0] filter_bytes[FILTER_DEPTH];
        logic [6:0] filter_len;
        logic       overflow;
        logic [6:0] position;
        mode_t      mode;
        verdict_t   verdict;
        rsp_t       expected_q[$];
        int         errors;

        function new();
            foreach (filter_bytes[i])
            begin
                filter_bytes[i] = 8'h00;
            end
            filter_len = '0;
            overflow = 1'b0;
            errors = 0;
            rewind();
        endfunction

        function void rewind();
            position = '0;
            mode = MODE_START;
            verdict = VERDICT_PENDING;
        endfunction

        function logic [7:0] filter_byte(int idx);
            if (idx >= filter_len)
            begin
                return 8'h00;
            end
            return filter_bytes[idx];
        endfunction

        function bit hash_tail(int fp);
            return fp < filter_len && fp + 1 == filter_len && filter_byte(fp) == CH_HASH;
        endfunction

        function bit seg_done(int fp);
            return fp >= filter_len || filter_byte(fp) == CH_SLASH;
        endfunction

        function void next_segment();
            if (position < filter_len)
            begin
                position = 7'(position + 7'd1);
            end
            mode = MODE_START;
        endfunction

        function void match_literal(logic [7:0] c);
            int fp;
            fp = position;
            if (c == CH_SLASH)
            begin
                if (seg_done(fp))
                begin
                    next_segment();
                end
                else
                begin
                    verdict = VERDICT_FAILED;
                end
            end
            else if (fp < filter_len && filter_byte(fp) != CH_SLASH && filter_byte(fp) == c)
            begin
                position = 7'(fp + 1);
            end
            else
            begin
                verdict = VERDICT_FAILED;
            end
        endfunction

        function void consume_topic(logic [7:0] c);
            int fp;
            fp = position;
            if (verdict != VERDICT_PENDING)
            begin
                return;
            end
            case (mode)
                MODE_START:
                begin
                    if (hash_tail(fp))
                    begin
                        verdict = VERDICT_MATCHED;
                    end
                    else if (fp >= filter_len)
                    begin
                        verdict = VERDICT_FAILED;
                    end
                    else if (filter_byte(fp) == CH_PLUS && seg_done(fp + 1))
                    begin
                        position = 7'(fp + 1);
                        mode = MODE_PLUS;
                        if (c == CH_SLASH)
                        begin
                            next_segment();
                        end
                    end
                    else
                    begin
                        mode = MODE_LITERAL;
                        match_literal(c);
                    end
                end
                MODE_PLUS:
                begin
                    if (c == CH_SLASH)
                    begin
                        next_segment();
                    end
                end
                default:
                begin
                    match_literal(c);
                end
            endcase
        endfunction

        function logic end_verdict();
            int fp;
            fp = position;
            if (overflow)
            begin
                return 1'b0;
            end
            if (verdict == VERDICT_MATCHED)
            begin
                return 1'b1;
            end
            if (verdict == VERDICT_FAILED)
            begin
                return 1'b0;
            end
            if (mode != MODE_START)
            begin
                if (mode == MODE_LITERAL && !seg_done(fp))
                begin
                    return 1'b0;
                end
                if (fp < filter_len)
                begin
                    fp++;
                end
            end
            return hash_tail(fp) || fp >= filter_len;
        endfunction

        function void note_request(req_t item);
            rsp_t want;
            case (op_t'(item.operation))
                OP_CLEAR:
                begin
                    filter_len = '0;
                    overflow = 1'b0;
                    rewind();
                end
                OP_FILTER:
                begin
                    if (filter_len < FILTER_DEPTH)
                    begin
                        filter_bytes[filter_len[5:0]] = item.char_byte;
                        filter_len = 7'(filter_len + 7'd1);
                    end
                    else
                    begin
                        overflow = 1'b1;
                    end
                    rewind();
                end
                OP_TOPIC:
                begin
                    consume_topic(item.char_byte);
                end
                default:
                begin
                    want.matched = end_verdict();
                    want.filter_overflow = overflow;
                    expected_q.push_back(want);
                    rewind();
                end
            endcase
        endfunction

        function void check_verdict(rsp_t got);
            rsp_t want;
            if (expected_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected verdict, got matched=%0b overflow=%0b",
                         $time, got.matched, got.filter_overflow);
                return;
            end
            want = expected_q.pop_front();
            if (got.matched !== want.matched)
            begin
                errors++;
                $display("%0t: matched expected %0b, got %0b", $time, want.matched, got.matched);
            end
            if (got.filter_overflow !== want.filter_overflow)
            begin
                errors++;
                $display("%0t: filter_overflow expected %0b, got %0b",
                         $time, want.filter_overflow, got.filter_overflow);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

endpackage

// ===== bench/testbench.sv =====
// testbench: drives filter loads and topics into topic_filter_match with random
// gaps and stalls, checks each verdict against tfm_verdict_sb_pkg
// depends on tfm_pkg, tfm_if, the rtl and tfm_verdict_scoreboard

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import tfm_pkg::*;
    import tfm_verdict_sb_pkg::*;

    typedef logic [7:0] text_t[$];

    localparam int TARGET_ITEMS = 1025;

    logic clk;
    logic rst_n;
    bit   quiet;
    int   sent_items;

    verdict_scoreboard sb = new();

    tfm_req_if req_bus();
    tfm_rsp_if rsp_bus();

    topic_filter_match #(
        .MAX_FILTER_LEN(FILTER_DEPTH)
    ) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
        begin
            sb.check_verdict(rsp_bus.payload);
        end
    end

    initial
    begin : verdict_sink
        int stall;
        rsp_bus.ready = 1'b0;
        forever
        begin
            stall = quiet ? 0 : $urandom_range(0, 13);
            if (stall > 0)
            begin
                @(negedge clk);
                rsp_bus.ready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            @(negedge clk);
            rsp_bus.ready <= 1'b1;
            do @(posedge clk); while (rsp_bus.valid !== 1'b1);
        end
    end

    task automatic send(op_t op, logic [7:0] ch);
        int   gap;
        req_t item;
        gap = quiet ? 0 : $urandom_range(0, 13);
        item.operation = op;
        item.char_byte = ch;
        if (gap > 0)
        begin
            @(negedge clk);
            req_bus.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        req_bus.valid <= 1'b1;
        req_bus.payload <= item;
        do @(posedge clk); while (req_bus.ready !== 1'b1);
        sb.note_request(item);
        sent_items++;
    endtask

    task automatic send_noise();
        send(op_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
    endtask

    task automatic load_filter(text_t f);
        send(OP_CLEAR, 8'($urandom_range(0, 255)));
        foreach (f[i])
        begin
            send(OP_FILTER, f[i]);
        end
    endtask

    task automatic send_topic(text_t t);
        foreach (t[i])
        begin
            // occasional broken sequence: stray op in the middle of a topic
            if ($urandom_range(0, 39) == 0)
            begin
                send_noise();
            end
            send(OP_TOPIC, t[i]);
        end
        send(OP_END, 8'($urandom_range(0, 255)));
    endtask

    task automatic wait_drained();
        @(negedge clk);
        req_bus.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
    endtask

    function automatic logic [7:0] word_char();
        case ($urandom_range(0, 7))
            0: return 8'($urandom_range(0, 255));
            1, 2, 3: return "a";
            default: return "b";
        endcase
    endfunction

    function automatic text_t long_filter(int n);
        text_t f;
        repeat (n)
        begin
            case ($urandom_range(0, 6))
                0: f.push_back(CH_SLASH);
                1: f.push_back(CH_PLUS);
                2: f.push_back(CH_HASH);
                default: f.push_back(word_char());
            endcase
        end
        return f;
    endfunction

    function automatic text_t make_filter();
        text_t f;
        int    segs;
        if ($urandom_range(0, 11) == 0)
        begin
            return long_filter($urandom_range(60, 70));
        end
        segs = $urandom_range(1, 4);
        for (int s = 0; s < segs; s++)
        begin
            if (s > 0)
            begin
                f.push_back(CH_SLASH);
            end
            case ($urandom_range(0, 9))
                0, 1, 2: f.push_back(CH_PLUS);
                3: f.push_back(CH_HASH);
                default:
                begin
                    repeat ($urandom_range(0, 3)) f.push_back(word_char());
                end
            endcase
        end
        if ($urandom_range(0, 9) == 0)
        begin
            f.push_back(CH_SLASH);
        end
        return f;
    endfunction

    // topic shaped after the filter, then sometimes damaged
    function automatic text_t topic_like(text_t f);
        text_t t;
        int    i;
        int    j;
        int    n;
        bit    done;
        i = 0;
        done = 1'b0;
        while (!done)
        begin
            j = i;
            while (j < f.size() && f[j] != CH_SLASH) j++;
            if (j == i + 1 && f[i] == CH_PLUS)
            begin
                repeat ($urandom_range(0, 2)) t.push_back(word_char());
            end
            else if (j == i + 1 && f[i] == CH_HASH)
            begin
                n = $urandom_range(0, 2);
                for (int k = 0; k < n; k++)
                begin
                    if (k > 0)
                    begin
                        t.push_back(CH_SLASH);
                    end
                    repeat ($urandom_range(0, 2)) t.push_back(word_char());
                end
            end
            else
            begin
                for (int k = i; k < j; k++)
                begin
                    t.push_back(f[k]);
                end
            end
            if (j >= f.size())
            begin
                done = 1'b1;
            end
            else
            begin
                t.push_back(CH_SLASH);
                i = j + 1;
            end
        end
        case ($urandom_range(0, 7))
            0:
            begin
                if (t.size() > 0)
                begin
                    t[$urandom_range(0, t.size() - 1)] = word_char();
                end
            end
            1: t.push_back(CH_SLASH);
            2:
            begin
                if (t.size() > 0)
                begin
                    void'(t.pop_back());
                end
            end
            3: t.push_back(word_char());
            default: ;
        endcase
        return t;
    endfunction

    initial
    begin : stimulus
        text_t f;
        bit    first;
        rst_n = 1'b0;
        req_bus.valid = 1'b0;
        req_bus.payload = '0;
        quiet = 1'b0;
        sent_items = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty filter against empty topic
        send(OP_END, 8'hFF);
        // filter a against topic a/
        send(OP_CLEAR, 8'h00);
        send(OP_FILTER, "a");
        send(OP_TOPIC, "a");
        send(OP_TOPIC, CH_SLASH);
        send(OP_END, 8'h00);
        // filter a/ against topic a
        send(OP_FILTER, CH_SLASH);
        send(OP_TOPIC, "a");
        send(OP_END, 8'h00);
        // trailing plus with an empty last segment, then a zero byte
        send(OP_CLEAR, 8'hFF);
        send(OP_FILTER, CH_PLUS);
        send(OP_END, 8'h00);
        send(OP_TOPIC, 8'h00);
        send(OP_END, 8'hFF);
        // hash with no rest and with a rest
        send(OP_CLEAR, 8'h00);
        send(OP_FILTER, CH_HASH);
        send(OP_END, 8'h55);
        send(OP_TOPIC, 8'hFF);
        send(OP_TOPIC, CH_SLASH);
        send(OP_END, 8'hAA);
        // filter cleared in the middle of a topic
        send(OP_TOPIC, "q");
        send(OP_CLEAR, 8'h55);
        send(OP_END, 8'hAA);

        first = 1'b1;
        while (sent_items < TARGET_ITEMS)
        begin
            quiet = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 7) == 0)
            begin
                repeat (20) send_noise();
            end
            else
            begin
                if (first)
                begin
                    f = long_filter(70);
                end
                else
                begin
                    f = make_filter();
                end
                load_filter(f);
                repeat ($urandom_range(1, 5))
                begin
                    send_topic(topic_like(f));
                end
            end
            if (first || $urandom_range(0, 5) == 0)
            begin
                wait_drained();
            end
            first = 1'b0;
        end

        wait_drained();
        repeat (8) @(posedge clk);
        if (sb.errors == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== topic_filter_match.f =====
rtl/tfm_pkg.sv
rtl/tfm_if.sv
rtl/tfm_filter_store.sv
rtl/tfm_matcher.sv
rtl/topic_filter_match.sv
bench/tfm_verdict_scoreboard.sv
bench/testbench.sv
